FILE: src/tip_pkg.sv
// Shared types and constants for the table interval interpolator.
// No dependencies; tip_if, tip_muldiv and the top level use it by scoped name.
package tip_pkg;

  localparam int VALUE_W         = 32;
  localparam int FIXED_COLUMNS   = 5;
  localparam int DEF_MAX_POINTS  = 64;
  localparam int DEF_NUM_COLUMNS = 13;
  localparam int MAG_W           = VALUE_W + 1;
  localparam int PROD_W          = 2 * MAG_W;

  localparam logic [1:0] OP_WRITE_X   = 2'd0;
  localparam logic [1:0] OP_WRITE_COL = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BELOW = 2'd2;
  localparam logic [1:0] ST_ABOVE = 2'd3;

  localparam logic REG_POINTS  = 1'b0;
  localparam logic REG_SPECIES = 1'b1;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [MAG_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] q;
  } md_rsp_t;

endpackage

FILE: src/tip_if.sv
// Channel interfaces: query/write input words and result words.
// Depends on tip_pkg for the value width.
interface tip_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [5:0]                  point_index;
  logic [3:0]                  column_index;
  logic [tip_pkg::VALUE_W-1:0] write_value;
  logic [tip_pkg::VALUE_W-1:0] query_x;
  modport source (output valid, opcode, point_index, column_index, write_value, query_x,
                  input ready);
  modport sink (input valid, opcode, point_index, column_index, write_value, query_x,
                output ready);
endinterface

interface tip_out_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  out_column;
  logic [tip_pkg::VALUE_W-1:0] result_value;
  logic [1:0]                  status;
  logic                        last;
  modport source (output valid, out_column, result_value, status, last, input ready);
  modport sink (input valid, out_column, result_value, status, last, output ready);
endinterface

FILE: src/tip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tip_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/tip_muldiv.sv
// Bit-serial unsigned multiply then restoring divide: q = a*b/d.
// Depends on tip_pkg for widths and the request/response structs.
module tip_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  tip_pkg::md_req_t req,
  output tip_pkg::md_rsp_t rsp
);
  localparam int MW = tip_pkg::MAG_W;
  localparam int PW = tip_pkg::PROD_W;
  localparam int CNW = $clog2(PW);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  md_state_t       state_r, state_nxt;
  logic [PW-1:0]   a_r, a_nxt, prod_r, prod_nxt;
  logic [MW-1:0]   b_r, b_nxt, d_r, d_nxt;
  logic [MW:0]     rem_r, rem_nxt, trial;
  logic [CNW-1:0]  cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic            ge;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    trial     = {rem_r[MW-1:0], prod_r[PW-1]};
    ge        = trial >= {1'b0, d_r};
    case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          a_nxt     = {{(PW-MW){1'b0}}, req.a};
          b_nxt     = req.b;
          d_nxt     = req.d;
          prod_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_nxt = prod_r + (b_r[0] ? a_r : '0);
        a_nxt    = a_r << 1;
        b_nxt    = b_r >> 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNW'(MW - 1)) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_nxt  = ge ? trial - {1'b0, d_r} : trial;
        prod_nxt = {prod_r[PW-2:0], ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNW'(PW - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = MD_IDLE;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = prod_r;
endmodule

FILE: src/table_interval_linear_interp_top.sv
// Table interval linear interpolator: top level with control sequencer.
// Depends on tip_pkg, tip_if, tip_ram and tip_muldiv.

// Breakpoint x values and property columns live in two RAMs that are loaded
// by write words (opcode 0 and 1) and read by query words (opcode 2). One
// word is handled at a time; in.ready is high only while the block is idle.
// A write completes without leaving the idle state. A query first scans x
// linearly for an exact match and, if none is found, runs a binary search
// (about log2(points_in_use)+1 steps). An exact match returns each column
// as read from the column RAM. Otherwise each column reads y1 and y2 and,
// unless the two breakpoint x values are equal (then y1 is returned),
// passes through the shared bit-serial multiply/divide unit (33 multiply
// then 66 divide steps); the next column starts only once it is done.
// Results are held in an output register, one column per word, last flagged.
// An empty table, or x outside the loaded range, gives one error word.
// Reading entries that were never written returns undefined data.
module table_interval_linear_interp_top #(
  parameter int MAX_POINTS  = tip_pkg::DEF_MAX_POINTS,
  parameter int NUM_COLUMNS = tip_pkg::DEF_NUM_COLUMNS
) (
  input  logic       clk,
  input  logic       rst_n,
  tip_in_if.sink     in_ch,
  tip_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);
  localparam int VW  = tip_pkg::VALUE_W;
  localparam int MW  = tip_pkg::MAG_W;
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int CAW = $clog2(MAX_POINTS * NUM_COLUMNS);
  localparam int CW  = $clog2(NUM_COLUMNS + 1);
  localparam int SW  = VW + 4;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_ERR      = 16'h0002,
    S_SCAN_RD  = 16'h0004,
    S_SCAN_CMP = 16'h0008,
    S_BS_RD    = 16'h0010,
    S_BS_CMP   = 16'h0020,
    S_XA_RD    = 16'h0040,
    S_XB_RD    = 16'h0080,
    S_XB_WAIT  = 16'h0100,
    S_Y1_RD    = 16'h0200,
    S_Y2_RD    = 16'h0400,
    S_Y_WAIT   = 16'h0800,
    S_MD_RUN   = 16'h1000,
    S_INT_OUT  = 16'h2000,
    S_COPY_RD  = 16'h4000,
    S_COPY_OUT = 16'h8000
  } state_t;

  state_t          state_r, state_nxt;
  logic [6:0]      points_r;
  logic [3:0]      species_r;
  logic [NW-1:0]   n_r, n_nxt, n_cfg;
  logic [CW-1:0]   ncols_r, ncols_nxt, ncols_cfg;
  logic [VW-1:0]   qx_r, qx_nxt;
  logic [NW-1:0]   i_r, i_nxt, lo_r, lo_nxt, cnt_r, cnt_nxt, half;
  logic [CAW-1:0]  base_r, base_nxt;
  logic [CW-1:0]   c_r, c_nxt;
  logic [VW-1:0]   x1_r, x1_nxt, x2_r, x2_nxt, y1_r, y1_nxt;
  logic [VW-1:0]   res_r, res_nxt;
  logic            neg_r, neg_nxt;
  logic [1:0]      err_r, err_nxt;

  // Output register.
  logic            ov_r, ov_nxt, olast_r, olast_nxt;
  logic [3:0]      ocol_r, ocol_nxt;
  logic [VW-1:0]   oval_r, oval_nxt;
  logic [1:0]      ost_r, ost_nxt;
  logic            slot_free;

  // RAM ports.
  logic            xwe, cwe;
  logic [PW-1:0]   xwaddr, xraddr;
  logic [CAW-1:0]  cwaddr, craddr;
  logic [VW-1:0]   xrd, crd;

  tip_pkg::md_req_t md_req;
  tip_pkg::md_rsp_t md_rsp;

  logic signed [MW-1:0] dx, dq, dy;
  logic signed [SW-1:0] sum;
  logic                 q_big;
  logic                 accept, in_range_pt, in_range_col;

  tip_ram #(.W(VW), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk, .we(xwe), .waddr(xwaddr), .wdata(in_ch.write_value),
    .raddr(xraddr), .rdata(xrd)
  );

  tip_ram #(.W(VW), .DEPTH(MAX_POINTS * NUM_COLUMNS)) u_col_ram (
    .clk, .we(cwe), .waddr(cwaddr), .wdata(in_ch.write_value),
    .raddr(craddr), .rdata(crd)
  );

  tip_muldiv u_md (.clk, .rst_n, .req(md_req), .rsp(md_rsp));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign slot_free    = !ov_r || out_ch.ready;
  assign in_range_pt  = 32'(in_ch.point_index) < 32'(MAX_POINTS);
  assign in_range_col = 32'(in_ch.column_index) < 32'(NUM_COLUMNS);

  // Writes land only while idle, so reads never collide with them.
  assign xwe    = accept && in_ch.opcode == tip_pkg::OP_WRITE_X && in_range_pt;
  assign cwe    = accept && in_ch.opcode == tip_pkg::OP_WRITE_COL && in_range_pt
                  && in_range_col;
  assign xwaddr = PW'(in_ch.point_index);
  assign cwaddr = CAW'(CAW'(xwaddr) * CAW'(NUM_COLUMNS) + CAW'(in_ch.column_index));

  // Saturate the configured counts to the table's size.
  assign n_cfg = (32'(points_r) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(points_r);
  assign ncols_cfg = CW'(tip_pkg::FIXED_COLUMNS) +
                     ((32'(species_r) > 32'(NUM_COLUMNS - tip_pkg::FIXED_COLUMNS)) ?
                      CW'(NUM_COLUMNS - tip_pkg::FIXED_COLUMNS) : CW'(species_r));

  assign half = cnt_r >> 1;

  // Interpolation operands: sign-extended differences. y2 is taken straight
  // from the column read port in S_Y_WAIT, where the unit captures the operands.
  assign dx = MW'(signed'(x2_r)) - MW'(signed'(x1_r));
  assign dq = MW'(signed'(qx_r)) - MW'(signed'(x1_r));
  assign dy = MW'(signed'(crd)) - MW'(signed'(y1_r));

  assign md_req.start = (state_r == S_Y_WAIT) && (dx != '0);
  assign md_req.a     = dy[MW-1] ? MW'(-dy) : MW'(dy);
  assign md_req.b     = dq[MW-1] ? MW'(-dq) : MW'(dq);
  assign md_req.d     = dx[MW-1] ? MW'(-dx) : MW'(dx);

  // Quotient above 2^34 saturates outright; otherwise add, then clamp.
  assign q_big = (|md_rsp.q[tip_pkg::PROD_W-1:35]) || (md_rsp.q[34] && |md_rsp.q[33:0]);
  assign sum   = neg_r ? SW'(signed'(y1_r)) - signed'(SW'(md_rsp.q[34:0]))
                       : SW'(signed'(y1_r)) + signed'(SW'(md_rsp.q[34:0]));

  always_comb begin
    xraddr = PW'(i_r);
    craddr = CAW'(base_r + CAW'(c_r));
    case (state_r)
      S_BS_RD:   xraddr = PW'(lo_r + half);
      S_XA_RD:   xraddr = PW'(lo_r - 1'b1);
      S_XB_RD:   xraddr = PW'(lo_r);
      S_Y2_RD:   craddr = CAW'(base_r + CAW'(NUM_COLUMNS) + CAW'(c_r));
      default:   ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    ncols_nxt = ncols_r;
    qx_nxt    = qx_r;
    i_nxt     = i_r;
    lo_nxt    = lo_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    c_nxt     = c_r;
    x1_nxt    = x1_r;
    x2_nxt    = x2_r;
    y1_nxt    = y1_r;
    res_nxt   = res_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ocol_nxt  = ocol_r;
    oval_nxt  = oval_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_ch.opcode == tip_pkg::OP_QUERY) begin
          qx_nxt    = in_ch.query_x;
          n_nxt     = n_cfg;
          ncols_nxt = ncols_cfg;
          i_nxt     = '0;
          if (n_cfg == '0) begin
            err_nxt   = tip_pkg::ST_EMPTY;
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ocol_nxt  = '0;
          oval_nxt  = '0;
          ost_nxt   = err_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        // First exact match wins; otherwise fall into the interval search.
        if (xrd == qx_r) begin
          base_nxt  = CAW'(CAW'(PW'(i_r)) * CAW'(NUM_COLUMNS));
          c_nxt     = '0;
          state_nxt = S_COPY_RD;
        end else if (i_r + 1'b1 == n_r) begin
          lo_nxt    = '0;
          cnt_nxt   = n_r;
          state_nxt = S_BS_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_BS_RD: begin
        if (cnt_r == '0) begin
          if (lo_r == '0) begin
            err_nxt   = tip_pkg::ST_BELOW;
            state_nxt = S_ERR;
          end else if (lo_r >= n_r) begin
            err_nxt   = tip_pkg::ST_ABOVE;
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_XA_RD;
          end
        end else begin
          state_nxt = S_BS_CMP;
        end
      end
      S_BS_CMP: begin
        if (!(signed'(qx_r) < signed'(xrd))) begin
          lo_nxt  = lo_r + half + 1'b1;
          cnt_nxt = cnt_r - half - 1'b1;
        end else begin
          cnt_nxt = half;
        end
        state_nxt = S_BS_RD;
      end
      S_XA_RD: state_nxt = S_XB_RD;
      S_XB_RD: begin
        x1_nxt    = xrd;
        state_nxt = S_XB_WAIT;
      end
      S_XB_WAIT: begin
        x2_nxt    = xrd;
        base_nxt  = CAW'(CAW'(PW'(lo_r - 1'b1)) * CAW'(NUM_COLUMNS));
        c_nxt     = '0;
        state_nxt = S_Y1_RD;
      end
      S_Y1_RD: state_nxt = S_Y2_RD;
      S_Y2_RD: begin
        y1_nxt    = crd;
        state_nxt = S_Y_WAIT;
      end
      S_Y_WAIT: begin
        if (dx == '0) begin
          res_nxt   = y1_r;
          state_nxt = S_INT_OUT;
        end else begin
          neg_nxt   = dy[MW-1] ^ dq[MW-1] ^ dx[MW-1];
          state_nxt = S_MD_RUN;
        end
      end
      S_MD_RUN: begin
        if (md_rsp.done) begin
          if (q_big) begin
            res_nxt = neg_r ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
          end else if (sum > SW'(signed'({1'b0, {(VW-1){1'b1}}}))) begin
            res_nxt = {1'b0, {(VW-1){1'b1}}};
          end else if (sum < SW'(signed'({1'b1, {(VW-1){1'b0}}}))) begin
            res_nxt = {1'b1, {(VW-1){1'b0}}};
          end else begin
            res_nxt = sum[VW-1:0];
          end
          state_nxt = S_INT_OUT;
        end
      end
      S_INT_OUT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ocol_nxt  = 4'(c_r);
          oval_nxt  = res_r;
          ost_nxt   = tip_pkg::ST_OK;
          olast_nxt = (c_r + 1'b1 == ncols_r);
          c_nxt     = c_r + 1'b1;
          state_nxt = (c_r + 1'b1 == ncols_r) ? S_IDLE : S_Y1_RD;
        end
      end
      S_COPY_RD: state_nxt = S_COPY_OUT;
      S_COPY_OUT: begin
        // Read address holds while stalled, so crd stays valid.
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ocol_nxt  = 4'(c_r);
          oval_nxt  = crd;
          ost_nxt   = tip_pkg::ST_OK;
          olast_nxt = (c_r + 1'b1 == ncols_r);
          c_nxt     = c_r + 1'b1;
          state_nxt = (c_r + 1'b1 == ncols_r) ? S_IDLE : S_COPY_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ov_r      <= 1'b0;
      points_r  <= '0;
      species_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tip_pkg::REG_POINTS:  points_r  <= cfg_data;
          tip_pkg::REG_SPECIES: species_r <= cfg_data[3:0];
          default:              ;
        endcase
      end
    end
    n_r     <= n_nxt;
    ncols_r <= ncols_nxt;
    qx_r    <= qx_nxt;
    i_r     <= i_nxt;
    lo_r    <= lo_nxt;
    cnt_r   <= cnt_nxt;
    base_r  <= base_nxt;
    c_r     <= c_nxt;
    x1_r    <= x1_nxt;
    x2_r    <= x2_nxt;
    y1_r    <= y1_nxt;
    res_r   <= res_nxt;
    neg_r   <= neg_nxt;
    err_r   <= err_nxt;
    ocol_r  <= ocol_nxt;
    oval_r  <= oval_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.out_column   = ocol_r;
  assign out_ch.result_value = oval_r;
  assign out_ch.status       = ost_r;
  assign out_ch.last         = olast_r;

  // Error words are single, zero-valued and final.
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != tip_pkg::ST_OK) |->
      (out_ch.last && out_ch.result_value == '0 && out_ch.out_column == '0))
    else $error("error word malformed");

  // No input is taken while the multiply/divide unit is busy.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MD_RUN) |-> !in_ch.ready)
    else $error("input accepted during arithmetic");

  // Unit finishes only while the sequencer waits on it.
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == S_MD_RUN))
    else $error("divider result dropped");
endmodule

FILE: tb/sv/table_interval_linear_interp_top_test.sv
// Self-checking testbench for the table interval linear interpolator.
// Depends on tip_pkg, tip_if and table_interval_linear_interp_top.
module table_interval_linear_interp_top_test;

  localparam int     POINTS     = tip_pkg::DEF_MAX_POINTS;
  localparam int     COLS       = tip_pkg::DEF_NUM_COLUMNS;
  localparam int     FIXED      = tip_pkg::FIXED_COLUMNS;
  localparam int     IDLE_LIMIT = 20000;
  localparam longint VMAX       = 64'sd2147483647;
  localparam longint VMIN       = -64'sd2147483648;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  pidx;
    logic [3:0]  cidx;
    logic [31:0] wv;
    logic [31:0] qx;
  } word_t;

  typedef struct {
    logic [3:0]  col;
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;
  } column_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_data;

  tip_in_if  in_if ();
  tip_out_if out_if ();

  table_interval_linear_interp_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Words waiting to be driven, and column results the block still owes.
  word_t          pending_words[$];
  column_result_t expected_columns[$];
  int             error_count = 0;
  int             word_count  = 0;

  // Predictor copy of the table and the registers.
  longint     tbl_x[POINTS];
  longint     tbl_col[POINTS][COLS];
  logic [6:0] pred_points;
  logic [3:0] pred_species;

  // Stimulus-side view of what has been loaded, so queries never touch
  // an entry that was never written.
  longint plan_x[POINTS];
  bit     col_loaded[POINTS][COLS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // One interpolated column: y1 + trunc(dy*dq/dx), saturated to 32 bits.
  function automatic logic [31:0] interp_column(longint x, longint x1, longint x2,
                                                longint y1, longint y2);
    longint          dx;
    longint          dq;
    longint          dy;
    longint          r;
    longint unsigned q;
    bit              neg;
    dx = x2 - x1;
    dq = x - x1;
    dy = y2 - y1;
    if (dx == 0) return y1[31:0];
    q   = (magnitude(dy) * magnitude(dq)) / magnitude(dx);
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    if (q > (64'd1 << 34)) return neg ? VMIN[31:0] : VMAX[31:0];
    r = neg ? y1 - longint'(q) : y1 + longint'(q);
    if (r > VMAX) r = VMAX;
    if (r < VMIN) r = VMIN;
    return r[31:0];
  endfunction

  function automatic void push_result(int col, logic [31:0] v, logic [1:0] st, bit lst);
    column_result_t r;
    r.col    = col[3:0];
    r.value  = v;
    r.status = st;
    r.last   = lst;
    expected_columns.push_back(r);
  endfunction

  // Work out every column result of one query against the current table.
  function automatic void predict_query(logic [31:0] qraw);
    longint qx;
    int     n;
    int     ncols;
    int     hit;
    int     lo;
    int     cnt;
    int     half;
    qx    = longint'(signed'(qraw));
    n     = (pred_points > POINTS) ? POINTS : int'(pred_points);
    ncols = FIXED + ((pred_species > COLS - FIXED) ? COLS - FIXED : int'(pred_species));
    if (n == 0) begin
      push_result(0, '0, tip_pkg::ST_EMPTY, 1'b1);
      return;
    end
    hit = -1;
    for (int i = 0; i < n; i++)
      if (hit < 0 && tbl_x[i] == qx) hit = i;
    if (hit >= 0) begin
      for (int c = 0; c < ncols; c++)
        push_result(c, tbl_col[hit][c][31:0], tip_pkg::ST_OK, c + 1 == ncols);
      return;
    end
    // Upper-bound binary search: first entry with x above the query.
    lo  = 0;
    cnt = n;
    while (cnt > 0) begin
      half = cnt / 2;
      if (!(qx < tbl_x[lo + half])) begin
        lo  = lo + half + 1;
        cnt = cnt - half - 1;
      end else begin
        cnt = half;
      end
    end
    if (lo == 0) begin
      push_result(0, '0, tip_pkg::ST_BELOW, 1'b1);
    end else if (lo >= n) begin
      push_result(0, '0, tip_pkg::ST_ABOVE, 1'b1);
    end else begin
      for (int c = 0; c < ncols; c++)
        push_result(c, interp_column(qx, tbl_x[lo-1], tbl_x[lo],
                                     tbl_col[lo-1][c], tbl_col[lo][c]),
                    tip_pkg::ST_OK, c + 1 == ncols);
    end
  endfunction

  // Driver: bursts of random length with random gaps. The predictor runs
  // on the word accepted at this edge, before the next word is presented.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        case (in_if.opcode)
          tip_pkg::OP_WRITE_X: begin
            tbl_x[in_if.point_index] = longint'(signed'(in_if.write_value));
          end
          tip_pkg::OP_WRITE_COL: begin
            if (in_if.column_index < COLS)
              tbl_col[in_if.point_index][in_if.column_index] =
                longint'(signed'(in_if.write_value));
          end
          tip_pkg::OP_QUERY: predict_query(in_if.query_x);
          default:           ;
        endcase
      end
      // Advance only when nothing is held, or the held word just went.
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_if.valid <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          in_if.valid        <= 1'b1;
          in_if.opcode       <= w.op;
          in_if.point_index  <= w.pidx;
          in_if.column_index <= w.cidx;
          in_if.write_value  <= w.wv;
          in_if.query_x      <= w.qx;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Some bursts run with no gap at all.
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Monitor: the receiver stalls on a pattern that is picked anew at random.
  int ready_cycle = 0;
  int stall_mode  = 0;

  always @(posedge clk) begin
    column_result_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_columns.size() == 0) begin
          report_mismatch("unexpected word", out_if.result_value, '0);
        end else begin
          e = expected_columns.pop_front();
          if (out_if.out_column !== e.col)
            report_mismatch("out_column", 32'(out_if.out_column), 32'(e.col));
          if (out_if.result_value !== e.value)
            report_mismatch("result_value", out_if.result_value, e.value);
          if (out_if.status !== e.status)
            report_mismatch("status", 32'(out_if.status), 32'(e.status));
          if (out_if.last !== e.last)
            report_mismatch("last", 32'(out_if.last), 32'(e.last));
        end
      end
      ready_cycle++;
      if (ready_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= (ready_cycle % 4 == 0);
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Watchdog: give up when nothing moves for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_word(logic [1:0] op, logic [5:0] pidx, logic [3:0] cidx,
                                    logic [31:0] wv, logic [31:0] qx, bit counted);
    word_t w;
    w.op   = op;
    w.pidx = pidx;
    w.cidx = cidx;
    w.wv   = wv;
    w.qx   = qx;
    pending_words.push_back(w);
    if (counted) word_count++;
  endfunction

  // Words the block must drop: opcode 3 and column writes past the table.
  function automatic void push_noise();
    if ($urandom_range(0, 1) == 0)
      push_word(2'd3, 6'($urandom), 4'($urandom), $urandom, $urandom, 0);
    else
      push_word(tip_pkg::OP_WRITE_COL, 6'($urandom),
                4'(COLS + $urandom_range(0, 15 - COLS)), $urandom, $urandom, 0);
  endfunction

  function automatic void push_query(logic [31:0] qx);
    push_word(tip_pkg::OP_QUERY, 6'($urandom), 4'($urandom), $urandom, qx, 1);
  endfunction

  // Hold until every word is in and every result is out, then let the
  // block finish any trailing write before touching the registers.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_if.valid || expected_columns.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_config(logic [6:0] points, logic [6:0] species);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tip_pkg::REG_POINTS;
    cfg_data  <= points;
    @(posedge clk);
    cfg_index <= tip_pkg::REG_SPECIES;
    cfg_data  <= species;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_points  = points;
    pred_species = species[3:0];
  endtask

  // Load x for every entry in use and any column not loaded yet; rewrite some loaded columns and mix in noise.
  function automatic void load_table(int n, int ncols, bit sorted, bit narrow);
    longint t;
    for (int i = 0; i < n; i++)
      plan_x[i] = narrow ? (longint'($urandom_range(0, 6)) - 3) * 65536
                         : longint'(signed'(rand_value()));
    if (sorted)
      for (int i = 1; i < n; i++)
        for (int j = i; j > 0 && plan_x[j-1] > plan_x[j]; j--) begin
          t           = plan_x[j];
          plan_x[j]   = plan_x[j-1];
          plan_x[j-1] = t;
        end
    for (int i = 0; i < n; i++) begin
      push_word(tip_pkg::OP_WRITE_X, 6'(i), 4'($urandom), plan_x[i][31:0], $urandom, 1);
      for (int c = 0; c < ncols; c++) begin
        if (!col_loaded[i][c] || $urandom_range(0, 3) == 0) begin
          push_word(tip_pkg::OP_WRITE_COL, 6'(i), 4'(c), rand_value(), $urandom, 1);
          col_loaded[i][c] = 1;
        end
        if ($urandom_range(0, 11) == 0) push_noise();
      end
    end
  endfunction

  // Mix of exact hits, points inside intervals and points off either end.
  function automatic void push_queries(int n, int count);
    longint          lo;
    longint          hi;
    longint unsigned span;
    int              i;
    for (int k = 0; k < count; k++) begin
      i = (n > 0) ? $urandom_range(0, n - 1) : 0;
      case ($urandom_range(0, 5))
        0, 1: push_query((n > 0) ? plan_x[i][31:0] : $urandom);
        2, 3: begin
          if (n > 1 && i < n - 1) begin
            lo   = (plan_x[i] < plan_x[i+1]) ? plan_x[i] : plan_x[i+1];
            hi   = (plan_x[i] < plan_x[i+1]) ? plan_x[i+1] : plan_x[i];
            span = hi - lo + 1;
            push_query(32'(lo + longint'({$urandom, $urandom} % span)));
          end else begin
            push_query($urandom);
          end
        end
        4:    push_query(($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        default: push_query($urandom);
      endcase
    end
  endfunction

  task automatic run_phase(logic [6:0] points, logic [6:0] species, bit sorted,
                           bit narrow, int queries);
    int n;
    int ncols;
    wait_idle();
    write_config(points, species);
    n     = (points > POINTS) ? POINTS : int'(points);
    ncols = FIXED + ((species[3:0] > COLS - FIXED) ? COLS - FIXED : int'(species[3:0]));
    if (n > 0) load_table(n, ncols, sorted, narrow);
    push_queries(n, queries);
  endtask

  initial begin
    int directed_words;
    int pick;
    logic [6:0] points;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = tip_pkg::REG_POINTS;
    cfg_data           = '0;
    in_if.valid        = 1'b0;
    in_if.opcode       = tip_pkg::OP_WRITE_X;
    in_if.point_index  = '0;
    in_if.column_index = '0;
    in_if.write_value  = '0;
    in_if.query_x      = '0;
    out_if.ready       = 1'b0;
    pred_points        = '0;
    pred_species       = '0;
    for (int i = 0; i < POINTS; i++) begin
      tbl_x[i] = 0;
      for (int c = 0; c < COLS; c++) begin
        tbl_col[i][c]    = 0;
        col_loaded[i][c] = 0;
      end
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, then the two widest breakpoints with every
    // column at an extreme, hit at both ends, between them, and noise.
    write_config(7'd0, 7'd0);
    push_query(32'h0);
    push_query(32'h8000_0000);
    wait_idle();
    write_config(7'd2, 7'd15);
    plan_x[0] = VMIN;
    plan_x[1] = VMAX;
    push_word(tip_pkg::OP_WRITE_X, 6'd0, 4'd0, 32'h8000_0000, 32'h0, 1);
    push_word(tip_pkg::OP_WRITE_X, 6'd1, 4'd0, 32'h7FFF_FFFF, 32'h0, 1);
    for (int c = 0; c < COLS; c++) begin
      push_word(tip_pkg::OP_WRITE_COL, 6'd0, 4'(c),
                (c % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, '0, 1);
      push_word(tip_pkg::OP_WRITE_COL, 6'd1, 4'(c),
                (c % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, '0, 1);
      col_loaded[0][c] = 1;
      col_loaded[1][c] = 1;
    end
    push_noise();
    push_query(32'h8000_0000);
    push_query(32'h7FFF_FFFF);
    push_query(32'h0);
    push_query(32'hFFFF_FFFF);
    directed_words = word_count;

    // Full table once, with the point count written past its range.
    run_phase(7'd100, 7'd0, 1, 0, 30);

    // Random phases: mostly small sorted tables, some unsorted ones to
    // reach equal interval ends and saturation.
    while (word_count < directed_words + 470) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)       points = 7'd0;
      else if (pick <= 14) points = 7'($urandom_range(1, 8));
      else                 points = 7'($urandom_range(9, 24));
      run_phase(points, 7'($urandom_range(0, 15)), $urandom_range(0, 3) != 0,
                1'($urandom_range(0, 1)), $urandom_range(6, 18));
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (expected_columns.size() != 0)
      report_mismatch("results never sent", 32'(expected_columns.size()), 32'd0);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
